[hdl/udst_pkg.sv]
// types and constants shared by the up/down staircase tracker
// no dependencies; imported by every module of the block
package udst_pkg;

	localparam int POS_W = 10;
	localparam int LEN_W = 11;
	localparam int CNT_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 11;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_UP_TARGET   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_TARGET = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TURNS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIST_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT  = 3'd5;

	// register reset values
	localparam logic [CNT_W-1:0] RST_UP_TARGET   = 8'd1;
	localparam logic [CNT_W-1:0] RST_DOWN_TARGET = 8'd1;
	localparam logic [CNT_W-1:0] RST_MAX_TURNS   = 8'd8;
	localparam logic [LEN_W-1:0] RST_LIST_LENGTH = 11'd1024;
	localparam logic [CNT_W-1:0] RST_LOW_LIMIT   = 8'd3;
	localparam logic [CNT_W-1:0] RST_HIGH_LIMIT  = 8'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;
	localparam int LEN_HW_CAP = 1024;

	localparam logic       OP_PREVIEW = 1'b0;
	localparam logic       OP_ADVANCE = 1'b1;
	localparam logic [1:0] ANS_ZERO   = 2'd0;
	localparam logic [1:0] ANS_ONE    = 2'd1;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		ST_RUN  = 2'd0,
		ST_TURN = 2'd1,
		ST_LOW  = 2'd2,
		ST_HIGH = 2'd3
	} status_t;

	// effective configuration, already clamped
	typedef struct packed {
		logic [CNT_W-1:0] up_target;
		logic [CNT_W-1:0] down_target;
		logic [CNT_W-1:0] max_turns;
		logic [LEN_W-1:0] length;
		logic [CNT_W-1:0] low_limit;
		logic [CNT_W-1:0] high_limit;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             started;
		logic [CNT_W-1:0] low_run;
		logic [CNT_W-1:0] high_run;
		dir_t             last_dir;
		logic [CNT_W-1:0] turns;
		logic [CNT_W-1:0] low_exceed;
		logic [CNT_W-1:0] high_exceed;
		status_t          status;
	} state_t;

	typedef struct packed {
		logic [POS_W-1:0] next_position;
		status_t          status;
		logic             was_turn;
	} result_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + 8'd1;
	endfunction

endpackage

[hdl/up_down_staircase_tracker.sv]
// top level of the up/down staircase tracker: state registers and result register
// depends on udst_pkg, udst_cfg and udst_step
//
// usage:
//   input channel (in_valid / in_stall) carries one request: opcode (0 preview,
//   1 advance and commit) and answer (0 kind zero, 1 kind one, 2 none).
//   output channel (out_valid / out_stall) returns one result per request:
//   next_position, status and was_turn.
//   configuration registers are written through cfg_we / cfg_index / cfg_data,
//   one register per cycle, while no request is in flight.
// result: registered, it appears in the cycle after the request is taken.
// throughput: one request per cycle unless in_stall; the staircase state register
//   feeds the next-state logic directly, so back-to-back advances see each other at once.
// stall: while a result waits in the output register with out_stall high,
//   in_stall is raised; a request is taken whenever the output register is empty
//   or is being emptied in the same cycle.
// reset: arst_n clears the staircase to position zero, not started, all counters
//   zero, status running, and loads the register defaults.
module up_down_staircase_tracker #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [udst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [udst_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic [1:0]                      answer,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [udst_pkg::POS_W-1:0]      next_position,
	output logic [1:0]                      status,
	output logic                            was_turn
);
	import udst_pkg::*;

	cfg_t    cfg;
	state_t  state_q;
	state_t  state_nx;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    in_acc;

	udst_cfg #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	udst_step u_step (
		.cfg   (cfg),
		.st    (state_q),
		.answer(answer),
		.nx    (state_nx),
		.res   (res)
	);

	assign in_stall = out_valid_q & out_stall;
	assign in_acc   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '{position: '0, started: 1'b0, low_run: '0, high_run: '0,
			                 last_dir: DIR_NONE, turns: '0, low_exceed: '0,
			                 high_exceed: '0, status: ST_RUN};
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc && opcode == OP_ADVANCE)
				state_q <= state_nx;
			if (in_acc)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload register, loaded only when a request is taken
	always_ff @(posedge clk) begin
		if (in_acc)
			res_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign next_position = res_q.next_position;
	assign status        = res_q.status;
	assign was_turn      = res_q.was_turn;

endmodule

[hdl/udst_cfg.sv]
// configuration registers of the staircase tracker with their clamping
// depends on udst_pkg
module udst_cfg #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [udst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [udst_pkg::CFG_DATA_W-1:0] cfg_data,
	output udst_pkg::cfg_t                cfg
);
	import udst_pkg::*;

	localparam int LEN_CAP = (MAX_ITEMS < LEN_HW_CAP) ? MAX_ITEMS : LEN_HW_CAP;

	logic [CNT_W-1:0] up_target_q, down_target_q, max_turns_q, low_limit_q, high_limit_q;
	logic [LEN_W-1:0] list_length_q;
	logic [LEN_W-1:0] len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_target_q   <= RST_UP_TARGET;
			down_target_q <= RST_DOWN_TARGET;
			max_turns_q   <= RST_MAX_TURNS;
			list_length_q <= RST_LIST_LENGTH;
			low_limit_q   <= RST_LOW_LIMIT;
			high_limit_q  <= RST_HIGH_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UP_TARGET:   up_target_q   <= cfg_data[CNT_W-1:0];
				REG_DOWN_TARGET: down_target_q <= cfg_data[CNT_W-1:0];
				REG_MAX_TURNS:   max_turns_q   <= cfg_data[CNT_W-1:0];
				REG_LIST_LENGTH: list_length_q <= cfg_data[LEN_W-1:0];
				REG_LOW_LIMIT:   low_limit_q   <= cfg_data[CNT_W-1:0];
				REG_HIGH_LIMIT:  high_limit_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		len = list_length_q;
		if (len == '0)
			len = 11'd1;
		if (len > LEN_W'(LEN_CAP))
			len = LEN_W'(LEN_CAP);
	end

	// zero targets act as one
	assign cfg.up_target   = (up_target_q == '0) ? 8'd1 : up_target_q;
	assign cfg.down_target = (down_target_q == '0) ? 8'd1 : down_target_q;
	assign cfg.max_turns   = max_turns_q;
	assign cfg.length      = len;
	assign cfg.low_limit   = low_limit_q;
	assign cfg.high_limit  = high_limit_q;

endmodule

[hdl/udst_step.sv]
// next-state and result logic for one staircase request
// depends on udst_pkg; purely combinational
module udst_step (
	input  udst_pkg::cfg_t    cfg,
	input  udst_pkg::state_t  st,
	input  logic [1:0]        answer,
	output udst_pkg::state_t  nx,
	output udst_pkg::result_t res
);
	import udst_pkg::*;

	dir_t             dir;
	status_t          status;
	logic             turn;
	logic [POS_W-1:0] cur;
	logic [LEN_W-1:0] cur_w;
	logic [LEN_W-1:0] nxt;

	always_comb begin
		nx     = st;
		dir    = DIR_NONE;
		status = ST_RUN;
		turn   = 1'b0;
		cur    = st.position;
		nxt    = '0;

		// before the first advance the answer refers to nothing
		if (!st.started) begin
			cur = '0;
		end else begin
			priority if (answer == ANS_ZERO) begin
				nx.high_run = '0;
				nx.low_run  = sat_inc(st.low_run);
				if (nx.low_run >= cfg.up_target) begin
					nx.low_run = '0;
					dir = DIR_DOWN;
				end
			end else if (answer == ANS_ONE) begin
				nx.low_run  = '0;
				nx.high_run = sat_inc(st.high_run);
				if (nx.high_run >= cfg.down_target) begin
					nx.high_run = '0;
					dir = DIR_UP;
				end
			end else begin
			end
			if (dir != DIR_NONE && st.last_dir != DIR_NONE && dir != st.last_dir) begin
				turn     = 1'b1;
				nx.turns = sat_inc(st.turns);
			end
		end
		if (dir != DIR_NONE)
			nx.last_dir = dir;

		cur_w = {1'b0, cur};
		priority if (nx.turns >= cfg.max_turns) begin
			status = ST_TURN;
		end else if (dir == DIR_DOWN && cur == '0) begin
			nx.low_exceed = sat_inc(st.low_exceed);
			if (nx.low_exceed >= cfg.low_limit)
				status = ST_LOW;
			else
				nx.position = '0;
		end else begin
			unique case (dir)
				DIR_UP:   nxt = cur_w + 11'd1;
				DIR_DOWN: nxt = cur_w - 11'd1;
				default:  nxt = cur_w;
			endcase
			if (nxt >= cfg.length) begin
				nx.high_exceed = sat_inc(st.high_exceed);
				if (nx.high_exceed >= cfg.high_limit)
					status = ST_HIGH;
				else if (cur_w < cfg.length)
					nx.position = cur;
				else
					nx.position = POS_W'(cfg.length - 11'd1);
			end else begin
				nx.position = nxt[POS_W-1:0];
			end
		end
		nx.status  = status;
		nx.started = 1'b1;

		res.next_position = (status == ST_RUN) ? nx.position : '0;
		res.status        = status;
		res.was_turn      = turn;

		// an ended run is sticky and changes nothing
		if (st.status != ST_RUN) begin
			nx                = st;
			res.next_position = '0;
			res.status        = st.status;
			res.was_turn      = 1'b0;
		end
	end

endmodule

[hdl/udst_checker.sv]
// port-level checks for the staircase tracker, bound to the top level
// depends on udst_pkg
module udst_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [udst_pkg::POS_W-1:0] next_position,
	input logic [1:0]                 status,
	input logic                       was_turn
);
	import udst_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_position)
			&& $stable(status) && $stable(was_turn))
		else $error("stalled result changed");

	// a taken request shows a result in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("result missing after request");

	// an empty output register never blocks the input
	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// an ended run reports position zero
	a_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_RUN |-> next_position == '0)
		else $error("nonzero position after end");

endmodule

bind up_down_staircase_tracker udst_checker u_udst_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.next_position(next_position),
	.status       (status),
	.was_turn     (was_turn)
);
